FILE: sv/ncr_pkg.sv
// ----------------------------------------------------------------------------
// ncr_pkg
// Shared types and constants for the numeric character reference decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ncr_pkg;

	// Default longest reference body between '&' and ';'
	localparam int MAX_REF_LEN_DEF = 10;

	localparam int UNIT_W = 16;

	// Digit accumulator: saturates at 0x10000, so 17 bits hold it
	localparam int ACC_W = 17;
	localparam logic [ACC_W-1:0] SAT_LIMIT  = 17'h10000;
	localparam logic [ACC_W-1:0] CODE_LIMIT = 17'h0FFFE;

	// Character codes
	localparam logic [UNIT_W-1:0] CH_AMP   = 16'h0026;
	localparam logic [UNIT_W-1:0] CH_SEMI  = 16'h003B;
	localparam logic [UNIT_W-1:0] CH_HASH  = 16'h0023;
	localparam logic [UNIT_W-1:0] CH_LX    = 16'h0078;
	localparam logic [UNIT_W-1:0] CH_UX    = 16'h0058;
	localparam logic [UNIT_W-1:0] CH_SPACE = 16'h0020;
	localparam logic [UNIT_W-1:0] CH_TAB   = 16'h0009;
	localparam logic [UNIT_W-1:0] CH_CR    = 16'h000D;
	localparam logic [UNIT_W-1:0] CH_PLUS  = 16'h002B;
	localparam logic [UNIT_W-1:0] CH_MINUS = 16'h002D;
	localparam logic [UNIT_W-1:0] CH_D0    = 16'h0030;
	localparam logic [UNIT_W-1:0] CH_D9    = 16'h0039;
	localparam logic [UNIT_W-1:0] CH_LA    = 16'h0061;
	localparam logic [UNIT_W-1:0] CH_LF    = 16'h0066;
	localparam logic [UNIT_W-1:0] CH_UA    = 16'h0041;
	localparam logic [UNIT_W-1:0] CH_UF    = 16'h0046;

	// Sequencer to window
	typedef struct packed {
		logic push;
		logic shift;
	} win_ctrl_t;

	// Window to sequencer
	typedef struct packed {
		logic front_amp;
		logic second_hash;
		logic third_x;
		logic semi_found;
	} win_flags_t;

	// Sequencer to number unit
	typedef struct packed {
		logic start;
		logic step;
		logic base16;
	} num_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/ncr_window.sv
// ----------------------------------------------------------------------------
// ncr_window
// Pending text window: append at the tail, shift out at the front, one
// read port for the number parser and a ';' finder over the filled entries behind the front.
// ----------------------------------------------------------------------------
`default_nettype none

module ncr_window #(
	parameter int WIN_DEPTH = ncr_pkg::MAX_REF_LEN_DEF + 2,
	localparam int IDX_W = $clog2(WIN_DEPTH),
	localparam int CNT_W = $clog2(WIN_DEPTH + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  ncr_pkg::win_ctrl_t             ctrl,
	input  wire logic [ncr_pkg::UNIT_W-1:0] push_unit,
	input  wire logic [IDX_W-1:0]          rd_idx,
	output logic [ncr_pkg::UNIT_W-1:0]     rd_unit,
	output logic [ncr_pkg::UNIT_W-1:0]     front_unit,
	output logic [CNT_W-1:0]               count,
	output ncr_pkg::win_flags_t            flags,
	output logic [IDX_W-1:0]               semi_idx
);
	import ncr_pkg::*;

	logic [UNIT_W-1:0] win_q [WIN_DEPTH];
	logic [CNT_W-1:0]  count_q;

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.shift) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Storage: tail write or shift toward the front
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			win_q[count_q[IDX_W-1:0]] <= push_unit;
		end else if (ctrl.shift) begin
			for (int k = 0; k < WIN_DEPTH - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
		end
	end

	// Front markers and the first ';' after the front among the filled entries
	always_comb begin
		flags.front_amp   = (win_q[0] == CH_AMP);
		flags.second_hash = (win_q[1] == CH_HASH);
		flags.third_x     = (win_q[2] == CH_LX) || (win_q[2] == CH_UX);
		flags.semi_found  = 1'b0;
		semi_idx          = '0;
		for (int k = WIN_DEPTH - 1; k >= 1; k--) begin
			if (win_q[k] == CH_SEMI && CNT_W'(k) < count_q) begin
				flags.semi_found = 1'b1;
				semi_idx         = IDX_W'(k);
			end
		end
	end

	assign rd_unit    = win_q[rd_idx];
	assign front_unit = win_q[0];
	assign count      = count_q;

endmodule

`default_nettype wire

FILE: sv/ncr_num_unit.sv
// ----------------------------------------------------------------------------
// ncr_num_unit
// Shared number parser: takes one character per step (space, sign, 0x
// prefix, digit) and accumulates the value with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ncr_num_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  ncr_pkg::num_ctrl_t              ctrl,
	input  wire logic [ncr_pkg::UNIT_W-1:0] unit,
	output logic                            fail,
	output logic                            good,
	output logic [ncr_pkg::UNIT_W-1:0]      value
);
	import ncr_pkg::*;

	localparam int MAC_W = ACC_W + 4;

	typedef enum logic [4:0] {
		PH_LEAD = 5'b00001,
		PH_SIGN = 5'b00010,
		PH_ZERO = 5'b00100,
		PH_XPFX = 5'b01000,
		PH_DIG  = 5'b10000
	} phase_t;

	phase_t           phase_q, phase_d;
	logic             neg_q, neg_d;
	logic             base16_q;
	logic [ACC_W-1:0] acc_q, acc_d;

	logic             is_space, is_plus, is_minus, is_zero, is_x;
	logic             is_dec, is_lhex, is_uhex, dig_ok;
	logic [3:0]       dval;
	logic [MAC_W-1:0] mac, sum;
	logic [ACC_W-1:0] acc_sat;

	// Character classes
	always_comb begin
		is_space = (unit == CH_SPACE) || (unit >= CH_TAB && unit <= CH_CR);
		is_plus  = (unit == CH_PLUS);
		is_minus = (unit == CH_MINUS);
		is_zero  = (unit == CH_D0);
		is_x     = (unit == CH_LX) || (unit == CH_UX);
		is_dec   = (unit >= CH_D0) && (unit <= CH_D9);
		is_lhex  = (unit >= CH_LA) && (unit <= CH_LF);
		is_uhex  = (unit >= CH_UA) && (unit <= CH_UF);
		dig_ok   = is_dec || (base16_q && (is_lhex || is_uhex));
		// letters a-f / A-F have low nibble 1..6
		dval     = is_dec ? unit[3:0] : (unit[3:0] + 4'd9);
	end

	// acc * base + digit, saturating
	always_comb begin
		if (base16_q) begin
			mac = MAC_W'(acc_q) << 4;
		end else begin
			mac = (MAC_W'(acc_q) << 3) + (MAC_W'(acc_q) << 1);
		end
		sum     = mac + MAC_W'(dval);
		acc_sat = (sum > MAC_W'(SAT_LIMIT)) ? SAT_LIMIT : sum[ACC_W-1:0];
	end

	// Phase step
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		fail    = 1'b0;
		case (phase_q)
			PH_LEAD: begin
				if (is_space) begin
					phase_d = PH_LEAD;
				end else if (is_plus) begin
					phase_d = PH_SIGN;
				end else if (is_minus) begin
					phase_d = PH_SIGN;
					neg_d   = 1'b1;
				end else if (base16_q && is_zero) begin
					phase_d = PH_ZERO;
				end else if (dig_ok) begin
					phase_d = PH_DIG;
					acc_d   = acc_sat;
				end else begin
					fail = 1'b1;
				end
			end
			PH_SIGN: begin
				if (base16_q && is_zero) begin
					phase_d = PH_ZERO;
				end else if (dig_ok) begin
					phase_d = PH_DIG;
					acc_d   = acc_sat;
				end else begin
					fail = 1'b1;
				end
			end
			PH_ZERO: begin
				if (is_x) begin
					phase_d = PH_XPFX;
				end else if (dig_ok) begin
					phase_d = PH_DIG;
					acc_d   = acc_sat;
				end else begin
					fail = 1'b1;
				end
			end
			PH_XPFX, PH_DIG: begin
				if (dig_ok) begin
					phase_d = PH_DIG;
					acc_d   = acc_sat;
				end else begin
					fail = 1'b1;
				end
			end
			default: begin
				fail = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			neg_q    <= 1'b0;
			base16_q <= 1'b0;
		end else if (ctrl.start) begin
			phase_q  <= PH_LEAD;
			neg_q    <= 1'b0;
			base16_q <= ctrl.base16;
		end else if (ctrl.step && !fail) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			acc_q <= '0;
		end else if (ctrl.step && !fail) begin
			acc_q <= acc_d;
		end
	end

	// Usable code unit: at least one digit, positive, below 0xFFFE
	assign good  = (phase_q == PH_DIG) && !neg_q && (acc_q != '0) && (acc_q < CODE_LIMIT);
	assign value = acc_q[UNIT_W-1:0];

endmodule

`default_nettype wire

FILE: sv/numeric_char_ref_decoder.sv
// ----------------------------------------------------------------------------
// numeric_char_ref_decoder
// Replaces &#digits; and &#xhex; references in a stream of 16-bit text
// units by the unit they name; everything else passes through in order.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   input   | in_valid, in_stall, code_unit,   | in
//           | last_unit                        |
//   output  | out_valid, out_stall, out_unit,  | out
//           | out_last                         |
//
// A word is accepted in IDLE; then the sequencer makes each window decision
// in EVAL, sends or drops units from the window one at a time in SHIFT, parses
// a numeric reference one character at a time in PARSE and then closes it,
// and sends a decoded unit from DEC.
// in_stall is high from acceptance until the window is resolved.
// out_stall holds the sequencer on the word waiting in the output register.
// Reset clears the fill count and the sequencer; window contents are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module numeric_char_ref_decoder #(
	parameter int MAX_REF_LEN = ncr_pkg::MAX_REF_LEN_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [ncr_pkg::UNIT_W-1:0] code_unit,
	input  wire logic                       last_unit,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [ncr_pkg::UNIT_W-1:0]      out_unit,
	output logic                            out_last
);
	import ncr_pkg::*;

	localparam int WIN_DEPTH = MAX_REF_LEN + 2;
	localparam int IDX_W     = $clog2(WIN_DEPTH);
	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EVAL  = 5'b00010,
		ST_PARSE = 5'b00100,
		ST_DEC   = 5'b01000,
		ST_SHIFT = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic              final_q;
	logic [CNT_W-1:0]  shift_cnt_q, shift_cnt_d;
	logic              shift_emit_q, shift_emit_d;
	logic [IDX_W-1:0]  idx_q, idx_d;

	win_ctrl_t         wctrl;
	win_flags_t        wflags;
	num_ctrl_t         nctrl;
	logic [UNIT_W-1:0] rd_unit, front_unit;
	logic [CNT_W-1:0]  count;
	logic [IDX_W-1:0]  semi_idx;
	logic              num_fail, num_good;
	logic [UNIT_W-1:0] num_value;

	logic              hex_ref;
	logic [CNT_W-1:0]  semi_len, prefix_len;
	logic              emit_ok, emit;
	logic [UNIT_W-1:0] emit_unit;
	logic              emit_last;

	logic              out_valid_q, out_last_q;
	logic [UNIT_W-1:0] out_unit_q;

	ncr_window #(
		.WIN_DEPTH(WIN_DEPTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (wctrl),
		.push_unit (code_unit),
		.rd_idx    (idx_q),
		.rd_unit   (rd_unit),
		.front_unit(front_unit),
		.count     (count),
		.flags     (wflags),
		.semi_idx  (semi_idx)
	);

	ncr_num_unit u_num (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (nctrl),
		.unit  (rd_unit),
		.fail  (num_fail),
		.good  (num_good),
		.value (num_value)
	);

	// Reference shape: hex marker, "&#" or "&#x" length, length through ';'
	assign hex_ref    = wflags.third_x && (semi_idx > IDX_W'(2));
	assign prefix_len = hex_ref ? CNT_W'(3) : CNT_W'(2);
	assign semi_len   = CNT_W'(semi_idx) + CNT_W'(1);

	assign emit_ok  = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Sequencer
	always_comb begin
		state_d      = state_q;
		shift_cnt_d  = shift_cnt_q;
		shift_emit_d = shift_emit_q;
		idx_d        = idx_q;
		wctrl        = '0;
		nctrl        = '0;
		nctrl.base16 = hex_ref;
		emit         = 1'b0;
		emit_unit    = front_unit;
		emit_last    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					wctrl.push = 1'b1;
					state_d    = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (count == '0) begin
					state_d = ST_IDLE;
				end else if (!wflags.front_amp) begin
					shift_cnt_d  = CNT_W'(1);
					shift_emit_d = 1'b1;
					state_d      = ST_SHIFT;
				end else if (!wflags.semi_found) begin
					// no ';' yet: give up on the '&' at the end or when full
					if (final_q || count == CNT_W'(WIN_DEPTH)) begin
						shift_cnt_d  = CNT_W'(1);
						shift_emit_d = 1'b1;
						state_d      = ST_SHIFT;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (semi_idx == IDX_W'(1)) begin
					// empty reference
					shift_cnt_d  = CNT_W'(2);
					shift_emit_d = 1'b1;
					state_d      = ST_SHIFT;
				end else if (!wflags.second_hash || CNT_W'(semi_idx) <= prefix_len) begin
					// named reference or empty numeric one: pass whole
					shift_cnt_d  = semi_len;
					shift_emit_d = 1'b1;
					state_d      = ST_SHIFT;
				end else begin
					nctrl.start = 1'b1;
					idx_d       = prefix_len[IDX_W-1:0];
					state_d     = ST_PARSE;
				end
			end
			ST_PARSE: begin
				if (idx_q == semi_idx) begin
					if (num_good) begin
						state_d = ST_DEC;
					end else begin
						shift_cnt_d  = prefix_len;
						shift_emit_d = 1'b1;
						state_d      = ST_SHIFT;
					end
				end else begin
					nctrl.step = 1'b1;
					if (num_fail) begin
						shift_cnt_d  = prefix_len;
						shift_emit_d = 1'b1;
						state_d      = ST_SHIFT;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			ST_DEC: begin
				// send the decoded unit, then drop the reference text
				if (emit_ok) begin
					emit         = 1'b1;
					emit_unit    = num_value;
					emit_last    = final_q && (semi_len == count);
					shift_cnt_d  = semi_len;
					shift_emit_d = 1'b0;
					state_d      = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (!shift_emit_q || emit_ok) begin
					wctrl.shift = 1'b1;
					emit        = shift_emit_q;
					emit_last   = final_q && (count == CNT_W'(1));
					shift_cnt_d = shift_cnt_q - CNT_W'(1);
					if (shift_cnt_q == CNT_W'(1)) begin
						state_d = ST_EVAL;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			final_q      <= 1'b0;
			shift_cnt_q  <= '0;
			shift_emit_q <= 1'b0;
			idx_q        <= '0;
		end else begin
			state_q      <= state_d;
			shift_cnt_q  <= shift_cnt_d;
			shift_emit_q <= shift_emit_d;
			idx_q        <= idx_d;
			if (state_q == ST_IDLE && in_valid) begin
				final_q <= last_unit;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_unit_q <= emit_unit;
			out_last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_unit  = out_unit_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire
